[hw/rtl/nodp_pkg.sv]
// types and constants shared by the note-off deadline pool
package nodp_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned PROD_W   = PERIOD_W + LEN_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd125000;

  typedef enum logic [1:0] {
    MODE_TRIGGER = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_FLUSH   = 2'd2
  } mode_t;

  // mode code with no action: taken and dropped
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [6:0] velocity;
    logic [3:0] channel;
    logic [6:0] number;
  } note_t;

  // broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    logic              step;
    logic              clear;
    mode_t             mode;
    logic [TIME_W-1:0] now;
  } cell_ctl_t;

endpackage

[hw/rtl/nodp_cell.sv]
// one slot of the pool: holds a pending note-off and passes the scan probe on
module nodp_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nodp_pkg::cell_ctl_t        ctl,
  input  logic                       probe_in,
  input  nodp_pkg::note_t            wr_note,
  input  logic [nodp_pkg::TIME_W-1:0] wr_deadline,
  output logic                       probe_out,
  output logic                       hit,
  output nodp_pkg::note_t            hit_note
);

  logic                        active_r;
  logic                        probe_r;
  nodp_pkg::note_t             note_r;
  logic [nodp_pkg::TIME_W-1:0] deadline_r;
  logic [nodp_pkg::TIME_W-1:0] diff;
  logic                        cond;

  // wrap-aware: due once now has reached the deadline
  assign diff = ctl.now - deadline_r;

  always_comb begin
    case (ctl.mode)
      nodp_pkg::MODE_TRIGGER: cond = !active_r;
      nodp_pkg::MODE_TICK:    cond = active_r && !diff[nodp_pkg::TIME_W-1];
      nodp_pkg::MODE_FLUSH:   cond = active_r;
      default:                cond = 1'b0;
    endcase
  end

  assign hit       = probe_r && cond;
  assign probe_out = probe_r;
  assign hit_note  = hit ? note_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      probe_r  <= 1'b0;
    end else begin
      if (ctl.clear) begin
        probe_r <= 1'b0;
      end else if (ctl.step) begin
        probe_r <= probe_in;
      end
      if (ctl.step && hit) begin
        active_r <= (ctl.mode == nodp_pkg::MODE_TRIGGER);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && hit && ctl.mode == nodp_pkg::MODE_TRIGGER) begin
      note_r     <= wr_note;
      deadline_r <= wr_deadline;
    end
  end

endmodule

[hw/rtl/note_off_deadline_pool.sv]
// pool of pending note-off slots: a probe walks the chain of slot cells, one per cycle unless stalled
// a request is taken while idle, then the probe visits the slots in order; a trigger ends
//   at the first free slot, or with the pool full sends its own note as the last note-off;
//   a tick or flush visits all SLOT_COUNT slots, and the run is then closed
// throughput: one request at a time; the next is taken while the final note-off sits in the
//   output register; the probe waits only when a note-off is held and the output is stalled
// reset: synchronous active-low; clears all slots, the output and the period to 125000 us
module note_off_deadline_pool #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nodp_pkg::PERIOD_W-1:0] cfg_step_period_us,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic [nodp_pkg::TIME_W-1:0]  in_now_us,
  input  logic [6:0]                   in_note_number,
  input  logic [3:0]                   in_note_channel,
  input  logic [6:0]                   in_note_velocity,
  input  logic [nodp_pkg::LEN_W-1:0]   in_length_steps,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [6:0]                   out_off_note_number,
  output logic [3:0]                   out_off_channel,
  output logic [6:0]                   out_off_velocity,
  output logic                         out_last_of_run
);

  nodp_pkg::state_t              state_r, state_nxt;
  logic [nodp_pkg::PERIOD_W-1:0] period_r;
  logic [1:0]                    mode_r;
  logic [nodp_pkg::TIME_W-1:0]   now_r;
  nodp_pkg::note_t               note_r;
  logic [nodp_pkg::TIME_W-1:0]   deadline_r;
  logic [nodp_pkg::PROD_W-1:0]   prod;

  logic                          hold_valid_r, hold_valid_nxt;
  nodp_pkg::note_t               hold_note_r, hold_note_nxt;

  logic                          out_valid_r;
  nodp_pkg::note_t               out_note_r, out_note_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_load;
  logic                          can_load;

  nodp_pkg::cell_ctl_t           ctl;
  logic                          inject;
  logic [SLOT_COUNT-1:0]         probes;
  logic [SLOT_COUNT-1:0]         hits;
  nodp_pkg::note_t               cell_notes [SLOT_COUNT];
  nodp_pkg::note_t               hit_note;
  logic                          probe_any;
  logic                          hit_any;
  logic                          accept;
  logic                          finish_need;
  nodp_pkg::note_t               finish_note;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == nodp_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_load  = !out_valid_r || out_ready;
  assign prod      = in_length_steps * period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= nodp_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period_r <= cfg_step_period_us;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_mode;
      now_r      <= in_now_us;
      note_r     <= '{velocity: in_note_velocity, channel: in_note_channel,
                      number: in_note_number};
      deadline_r <= in_now_us + {{(nodp_pkg::TIME_W - nodp_pkg::PROD_W){1'b0}}, prod};
    end
  end

  // chain of slot cells
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    logic probe_in;
    if (i == 0) begin : g_head
      assign probe_in = inject;
    end else begin : g_link
      assign probe_in = probes[i-1];
    end
    nodp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .probe_in   (probe_in),
      .wr_note    (note_r),
      .wr_deadline(deadline_r),
      .probe_out  (probes[i]),
      .hit        (hits[i]),
      .hit_note   (cell_notes[i])
    );
  end

  // at most one cell holds the probe, so an or of the gated notes selects it
  always_comb begin
    hit_note = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_note = hit_note | cell_notes[i];
    end
  end

  assign probe_any = |probes;
  assign hit_any   = |hits;

  always_comb begin
    if (nodp_pkg::mode_t'(mode_r) == nodp_pkg::MODE_TRIGGER) begin
      finish_need = 1'b1;
      finish_note = note_r;
    end else begin
      finish_need = hold_valid_r;
      finish_note = hold_note_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ctl.step       = 1'b0;
    ctl.clear      = 1'b0;
    ctl.mode       = nodp_pkg::mode_t'(mode_r);
    ctl.now        = now_r;
    inject         = 1'b0;
    hold_valid_nxt = hold_valid_r;
    hold_note_nxt  = hold_note_r;
    out_load       = 1'b0;
    out_note_nxt   = hold_note_r;
    out_last_nxt   = 1'b0;
    unique case (state_r)
      nodp_pkg::ST_IDLE: begin
        if (accept && in_mode != nodp_pkg::MODE_UNUSED) begin
          ctl.step  = 1'b1;
          inject    = 1'b1;
          state_nxt = nodp_pkg::ST_SCAN;
        end
      end
      nodp_pkg::ST_SCAN: begin
        if (!probe_any) begin
          // end of the chain: close the run
          if (!finish_need) begin
            hold_valid_nxt = 1'b0;
            state_nxt      = nodp_pkg::ST_IDLE;
          end else if (can_load) begin
            out_load       = 1'b1;
            out_note_nxt   = finish_note;
            out_last_nxt   = 1'b1;
            hold_valid_nxt = 1'b0;
            state_nxt      = nodp_pkg::ST_IDLE;
          end
        end else if (hit_any) begin
          if (nodp_pkg::mode_t'(mode_r) == nodp_pkg::MODE_TRIGGER) begin
            ctl.step  = 1'b1;
            ctl.clear = 1'b1;
            state_nxt = nodp_pkg::ST_IDLE;
          end else if (!hold_valid_r || can_load) begin
            // held note-off is not the last one, send it and keep this one back
            ctl.step       = 1'b1;
            out_load       = hold_valid_r;
            hold_valid_nxt = 1'b1;
            hold_note_nxt  = hit_note;
          end
        end else begin
          ctl.step = 1'b1;
        end
      end
      default: begin
        state_nxt = nodp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nodp_pkg::ST_IDLE;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hold_valid_r <= hold_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_note_r <= hold_note_nxt;
    if (out_load) begin
      out_note_r <= out_note_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_off_note_number = out_note_r.number;
  assign out_off_channel     = out_note_r.channel;
  assign out_off_velocity    = out_note_r.velocity;
  assign out_last_of_run     = out_last_r;

  a_probe_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(probes))
    else $error("more than one cell holds the probe");

  a_probe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    probe_any |-> state_r == nodp_pkg::ST_SCAN)
    else $error("probe alive outside a scan");

  a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nodp_pkg::ST_IDLE |-> !hold_valid_r)
    else $error("held note-off left behind after a run");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// testbench for note_off_deadline_pool: directed and random requests against a pool model
module tb_top;

  localparam int unsigned SLOTS           = 8;
  localparam int unsigned ITEMS_PER_PHASE = 64;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = SLOTS + 6;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    logic [6:0] number;
    logic [3:0] channel;
    logic [6:0] velocity;
    logic       last;
  } note_off_t;

  class note_off_scoreboard;
    logic [nodp_pkg::PERIOD_W-1:0] period;
    bit                            busy [SLOTS];
    nodp_pkg::note_t               held_note [SLOTS];
    logic [nodp_pkg::TIME_W-1:0]   deadline [SLOTS];
    note_off_t                     pending_offs [$];
    int                            mismatches;

    function new();
      period = nodp_pkg::PERIOD_RESET;
      foreach (busy[i]) busy[i] = 1'b0;
      mismatches = 0;
    endfunction

    function void set_period(logic [nodp_pkg::PERIOD_W-1:0] p);
      period = p;
    endfunction

    function int outstanding();
      return pending_offs.size();
    endfunction

    // works out the note-offs that one accepted request releases
    function void accept_request(logic [1:0] mode, logic [nodp_pkg::TIME_W-1:0] now,
                                 logic [6:0] num, logic [3:0] chan, logic [6:0] vel,
                                 logic [nodp_pkg::LEN_W-1:0] len);
      note_off_t                   off;
      logic [nodp_pkg::TIME_W-1:0] diff;
      int                          count;
      bit                          placed;
      count  = 0;
      placed = 1'b0;
      case (mode)
        nodp_pkg::MODE_TRIGGER: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !busy[i]) begin
              held_note[i].number   = num;
              held_note[i].channel  = chan;
              held_note[i].velocity = vel;
              deadline[i] = now + nodp_pkg::TIME_W'(len) * nodp_pkg::TIME_W'(period);
              busy[i] = 1'b1;
              placed  = 1'b1;
            end
          end
          // pool full: the note is released straight away
          if (!placed) begin
            off = {num, chan, vel, 1'b1};
            pending_offs.push_back(off);
          end
        end
        nodp_pkg::MODE_TICK, nodp_pkg::MODE_FLUSH: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (busy[i]) begin
              diff = now - deadline[i];
              if (mode == nodp_pkg::MODE_FLUSH || !diff[nodp_pkg::TIME_W-1]) begin
                off = {held_note[i].number, held_note[i].channel, held_note[i].velocity,
                       1'b0};
                pending_offs.push_back(off);
                busy[i] = 1'b0;
                count++;
              end
            end
          end
          if (count > 0) begin
            off = pending_offs.pop_back();
            off.last = 1'b1;
            pending_offs.push_back(off);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_off(note_off_t got);
      note_off_t want;
      bit        bad;
      if (pending_offs.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected note-off at %0t: note %0d ch %0d vel %0d last %0b",
                   $time, got.number, got.channel, got.velocity, got.last);
        mismatches++;
        return;
      end
      want = pending_offs.pop_front();
      bad = (got.number != want.number) || (got.channel != want.channel) ||
            (got.velocity != want.velocity) || (got.last != want.last);
      if (bad) begin
        if (mismatches < MAX_REPORTS) begin
          $display("note-off mismatch at %0t: expected note %0d ch %0d vel %0d last %0b",
                   $time, want.number, want.channel, want.velocity, want.last);
          $display("  got note %0d ch %0d vel %0d last %0b",
                   got.number, got.channel, got.velocity, got.last);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk                = 1'b0;
  logic                          rst_n              = 1'b0;
  logic                          cfg_valid          = 1'b0;
  logic                          cfg_ready;
  logic [nodp_pkg::PERIOD_W-1:0] cfg_step_period_us = '0;
  logic                          in_valid           = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_mode            = '0;
  logic [nodp_pkg::TIME_W-1:0]   in_now_us          = '0;
  logic [6:0]                    in_note_number     = '0;
  logic [3:0]                    in_note_channel    = '0;
  logic [6:0]                    in_note_velocity   = '0;
  logic [nodp_pkg::LEN_W-1:0]    in_length_steps    = '0;
  logic                          out_valid;
  logic                          out_ready          = 1'b0;
  logic [6:0]                    out_off_note_number;
  logic [3:0]                    out_off_channel;
  logic [6:0]                    out_off_velocity;
  logic                          out_last_of_run;

  note_off_scoreboard          pool_sb = new();
  int unsigned                 in_idle_pct  = 28;
  int unsigned                 out_idle_pct = 62;
  bit                          rx_hold      = 1'b0;
  logic [nodp_pkg::TIME_W-1:0] clock_us     = '0;

  note_off_deadline_pool #(.SLOT_COUNT(SLOTS)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_step_period_us (cfg_step_period_us),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_now_us          (in_now_us),
    .in_note_number     (in_note_number),
    .in_note_channel    (in_note_channel),
    .in_note_velocity   (in_note_velocity),
    .in_length_steps    (in_length_steps),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_off_note_number(out_off_note_number),
    .out_off_channel    (out_off_channel),
    .out_off_velocity   (out_off_velocity),
    .out_last_of_run    (out_last_of_run)
  );

  always #5 clk = ~clk;

  // result side: check on handshake, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      pool_sb.check_off({out_off_note_number, out_off_channel, out_off_velocity,
                         out_last_of_run});
    if (rx_hold)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic send_request(logic [1:0] mode, logic [nodp_pkg::TIME_W-1:0] now,
                              logic [6:0] num, logic [3:0] chan, logic [6:0] vel,
                              logic [nodp_pkg::LEN_W-1:0] len);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_now_us        <= now;
    in_note_number   <= num;
    in_note_channel  <= chan;
    in_note_velocity <= vel;
    in_length_steps  <= len;
    do @(posedge clk); while (!in_ready);
    pool_sb.accept_request(mode, now, num, chan, vel, len);
  endtask

  // let every note-off drain and give a trailing trigger scan time to finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pool_sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [nodp_pkg::PERIOD_W-1:0] p);
    settle();
    cfg_valid          <= 1'b1;
    cfg_step_period_us <= p;
    do @(posedge clk); while (!cfg_ready);
    pool_sb.set_period(p);
    cfg_valid <= 1'b0;
  endtask

  // mostly a coherent timeline of triggers and ticks, with some noise and unused modes
  task automatic random_request(output bit counts);
    logic [1:0]                  mode;
    logic [nodp_pkg::TIME_W-1:0] now;
    logic [nodp_pkg::TIME_W-1:0] adv;
    logic [nodp_pkg::TIME_W-1:0] per;
    int unsigned                 r;
    r   = $urandom_range(0, 99);
    per = nodp_pkg::TIME_W'(pool_sb.period);
    now = clock_us;
    if (r < 8) begin
      mode = 2'($urandom_range(0, 3));
      now  = $urandom();
    end else if (r < 12) begin
      mode = nodp_pkg::MODE_UNUSED;
    end else if (r < 55) begin
      mode = nodp_pkg::MODE_TRIGGER;
    end else if (r < 90) begin
      mode = nodp_pkg::MODE_TICK;
      case ($urandom_range(0, 3))
        0:       adv = '0;
        1:       adv = $urandom_range(0, per);
        2:       adv = per * $urandom_range(1, 8);
        default: adv = per * $urandom_range(0, 16) + $urandom_range(0, 3);
      endcase
      clock_us = clock_us + adv;
      now      = clock_us;
    end else begin
      mode = nodp_pkg::MODE_FLUSH;
    end
    send_request(mode, now, 7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                 7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
    counts = (mode != nodp_pkg::MODE_UNUSED);
  endtask

  initial begin
    logic [nodp_pkg::TIME_W-1:0]   far;
    logic [nodp_pkg::TIME_W-1:0]   due_at;
    logic [nodp_pkg::PERIOD_W-1:0] per;
    int unsigned                   counted;
    bit                            c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero-length note, fill the pool across the time wrap, overflow
    far = 32'hFFFF_FFF0;
    send_request(nodp_pkg::MODE_TRIGGER, '0, 7'd0, 4'd0, 7'd0, 4'd0);
    send_request(nodp_pkg::MODE_TICK, '0, 7'd0, 4'd0, 7'd0, 4'd0);
    for (int k = 0; k < SLOTS; k++)
      send_request(nodp_pkg::MODE_TRIGGER, far, 7'(127 - k), 4'd15, 7'd127, 4'(8 + k));
    send_request(nodp_pkg::MODE_TRIGGER, far, 7'h55, 4'hA, 7'h2A, 4'hF);
    send_request(nodp_pkg::MODE_TICK, far - 1, 7'd0, 4'd0, 7'd0, 4'd0);
    send_request(nodp_pkg::MODE_TICK, far + 10 * 125000, 7'd0, 4'd0, 7'd0, 4'd0);
    send_request(nodp_pkg::MODE_UNUSED, '1, 7'h7F, 4'hF, 7'h7F, 4'hF);
    send_request(nodp_pkg::MODE_FLUSH, '0, 7'd0, 4'd0, 7'd0, 4'd0);
    send_request(nodp_pkg::MODE_FLUSH, '0, 7'd0, 4'd0, 7'd0, 4'd0);

    // zero period, and the half-range boundary of the signed difference
    write_period('0);
    send_request(nodp_pkg::MODE_TRIGGER, 32'd100, 7'd60, 4'd3, 7'd90, 4'd15);
    send_request(nodp_pkg::MODE_TICK, 32'd100 + 32'h8000_0000, 7'd0, 4'd0, 7'd0, 4'd0);
    send_request(nodp_pkg::MODE_TICK, 32'd100 + 32'h7FFF_FFFF, 7'd0, 4'd0, 7'd0, 4'd0);

    write_period('1);
    due_at = 32'h8000_0000 + 15 * 32'h000F_FFFF;
    send_request(nodp_pkg::MODE_TRIGGER, 32'h8000_0000, 7'd1, 4'd1, 7'd1, 4'd15);
    send_request(nodp_pkg::MODE_TICK, due_at - 1, 7'd0, 4'd0, 7'd0, 4'd0);
    send_request(nodp_pkg::MODE_TICK, due_at, 7'd0, 4'd0, 7'd0, 4'd0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin in_idle_pct = 28; out_idle_pct = 62; per = 20'd1; end
        1: begin in_idle_pct = 62; out_idle_pct = 28; per = 20'd1000000; end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          per = 20'($urandom_range(2, 999999));
        end
      endcase
      write_period(per);
      // start just short of the wrap so deadlines cross it
      clock_us = 32'd0 - $urandom_range(0, 20 * per + 100);
      if (p == 2) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        random_request(c);
        counted += c;
      end
    end

    settle();
    if (pool_sb.mismatches == 0 && pool_sb.outstanding() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
